// ----- sv/hdc_pkg.sv -----
// hdc_pkg: types, codes and reset constants shared by the hit clustering block
// depends on nothing; used by every module of hit_diagonal_clustering
`default_nettype none

package hdc_pkg;

  localparam int unsigned MAX_CLUSTERS_DEF = 1024;

  localparam logic [3:0] DIAG_TOL_RST = 4'd2;
  localparam logic [7:0] MAX_GAP_RST  = 8'd48;
  localparam logic [3:0] SLACK_RST    = 4'd2;
  localparam logic [5:0] TILE_RST     = 6'd16;

  localparam logic [15:0] HITS_MAX = 16'hFFFF;

  typedef enum logic [1:0] {
    ACT_ADD   = 2'd0,
    ACT_READ  = 2'd1,
    ACT_CLEAR = 2'd2
  } hdc_action_e;

  typedef enum logic [1:0] {
    CFG_DIAG_TOL = 2'd0,
    CFG_MAX_GAP  = 2'd1,
    CFG_SLACK    = 2'd2,
    CFG_TILE     = 2'd3
  } hdc_cfg_idx_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN_RD,
    ST_SCAN_CHK,
    ST_APPEND,
    ST_RD_ISSUE,
    ST_RD_DONE
  } hdc_state_e;

  typedef struct packed {
    logic [3:0] diag_tol;
    logic [7:0] max_gap;
    logic [3:0] slack;
    logic [5:0] tile;
  } hdc_cfg_t;

  // one cluster table row; seed diagonal kept so the scan needs a single subtract
  typedef struct packed {
    logic [15:0]        probe_start;
    logic [16:0]        probe_end;
    logic [29:0]        target_start;
    logic [30:0]        target_end;
    logic [15:0]        hits;
    logic signed [31:0] seed_diag;
  } hdc_entry_t;

  // incoming hit with the window bounds precomputed at accept
  typedef struct packed {
    logic [15:0]        probe;
    logic [29:0]        target;
    logic signed [31:0] diag;
    logic [16:0]        probe_slack;
    logic [30:0]        target_slack;
  } hdc_hit_t;

endpackage

`default_nettype wire

// ----- sv/hdc_cluster_mem.sv -----
// hdc_cluster_mem: cluster table, one write and one registered read port
// depends on hdc_pkg for the row type
`default_nettype none

module hdc_cluster_mem #(
  parameter int unsigned DEPTH = hdc_pkg::MAX_CLUSTERS_DEF,
  parameter int unsigned AW    = $clog2(DEPTH)
) (
  input  wire                      clk_i,
  input  wire                      rd_en_i,
  input  wire  [AW-1:0]            rd_addr_i,
  output hdc_pkg::hdc_entry_t      rd_data_o,
  input  wire                      wr_en_i,
  input  wire  [AW-1:0]            wr_addr_i,
  input  hdc_pkg::hdc_entry_t      wr_data_i
);

  hdc_pkg::hdc_entry_t mem [DEPTH];
  hdc_pkg::hdc_entry_t rd_data_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem[wr_addr_i] <= wr_data_i;
    end
    if (rd_en_i) begin
      rd_data_q <= mem[rd_addr_i];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

`default_nettype wire

// ----- sv/hdc_match.sv -----
// hdc_match: join test of one hit against one cluster row
// depends on hdc_pkg for the hit, row and config types
`default_nettype none

module hdc_match (
  input  hdc_pkg::hdc_hit_t   hit_i,
  input  hdc_pkg::hdc_entry_t entry_i,
  input  hdc_pkg::hdc_cfg_t   cfg_i,
  output logic                join_o
);

  logic signed [32:0] dd;
  logic signed [32:0] tol_s;
  logic               diag_ok;
  logic [17:0]        probe_far;
  logic [31:0]        target_far;
  logic               probe_ok;
  logic               target_ok;

  always_comb begin
    dd      = 33'(hit_i.diag) - 33'(entry_i.seed_diag);
    tol_s   = $signed({29'd0, cfg_i.diag_tol});
    diag_ok = (dd <= tol_s) && (dd >= -tol_s);

    // end - slack <= pos is tested as end <= pos + slack
    probe_far  = 18'(entry_i.probe_end) + 18'(cfg_i.max_gap);
    probe_ok   = (entry_i.probe_end <= hit_i.probe_slack) &&
                 ({2'b00, hit_i.probe} <= probe_far);
    target_far = 32'(entry_i.target_end) + 32'(cfg_i.max_gap);
    target_ok  = (entry_i.target_end <= hit_i.target_slack) &&
                 ({2'b00, hit_i.target} <= target_far);

    join_o = diag_ok && probe_ok && target_ok;
  end

endmodule

`default_nettype wire

// ----- sv/hit_diagonal_clustering.sv -----
// add: busy while each cluster is read in ST_SCAN_RD and tested in ST_SCAN_CHK; a join
// ends the add, else ST_APPEND opens a cluster; an empty table goes straight to ST_APPEND
// read: busy in ST_RD_ISSUE and ST_RD_DONE; the result strobe is registered from ST_RD_DONE
// clear and unused codes: busy is never raised. results cannot be stalled
// reset clears cluster count and overflow flag and loads default config; rows kept
// top level of the hit clustering block; depends on hdc_pkg, hdc_cluster_mem, hdc_match
`default_nettype none

module hit_diagonal_clustering #(
  parameter int unsigned MAX_CLUSTERS = hdc_pkg::MAX_CLUSTERS_DEF
) (
  input  wire         clk_i,
  input  wire         rst_ni,
  input  wire         start_i,
  output logic        busy_o,
  input  wire  [1:0]  action_i,
  input  wire  [15:0] probe_offset_i,
  input  wire  [29:0] target_offset_i,
  input  wire  [9:0]  cluster_index_i,
  input  wire         cfg_valid_i,
  output logic        cfg_ready_o,
  input  wire  [1:0]  cfg_index_i,
  input  wire  [7:0]  cfg_data_i,
  output logic        result_valid_o,
  output logic [15:0] probe_start_o,
  output logic [16:0] probe_end_o,
  output logic [29:0] target_start_o,
  output logic [30:0] target_end_o,
  output logic [15:0] hit_total_o,
  output logic [10:0] cluster_total_o,
  output logic        index_valid_o,
  output logic        overflowed_o
);

  localparam int unsigned CIDX_W = $clog2(MAX_CLUSTERS);
  localparam int unsigned CNT_W  = $clog2(MAX_CLUSTERS + 1);
  localparam int unsigned CMP_W  = (CNT_W > 10) ? CNT_W : 10;

  hdc_pkg::hdc_state_e state_q, state_d;
  hdc_pkg::hdc_cfg_t   cfg_q, cfg_d;
  hdc_pkg::hdc_hit_t   hit_q, hit_d;
  hdc_pkg::hdc_entry_t rd_data, wr_data, new_entry, join_entry;

  logic [CIDX_W-1:0] scan_q, scan_d;
  logic [CNT_W-1:0]  count_q, count_d;
  logic              ovf_q, ovf_d;
  logic [CIDX_W-1:0] idx_q, idx_d;
  logic              idx_ok_q, idx_ok_d;

  logic              rd_en, wr_en;
  logic [CIDX_W-1:0] rd_addr, wr_addr;
  logic              join_hit;
  logic              scan_last;
  logic              table_full;
  logic              accept;
  logic [CMP_W-1:0]  idx_cmp;

  logic        res_valid_q, res_valid_d;
  logic [15:0] res_ps_q, res_ps_d;
  logic [16:0] res_pe_q, res_pe_d;
  logic [29:0] res_ts_q, res_ts_d;
  logic [30:0] res_te_q, res_te_d;
  logic [15:0] res_hits_q, res_hits_d;
  logic [10:0] res_total_q, res_total_d;
  logic        res_iv_q, res_iv_d;
  logic        res_ovf_q, res_ovf_d;

  assign accept      = start_i && !busy_o;
  assign busy_o      = (state_q != hdc_pkg::ST_IDLE);
  assign cfg_ready_o = 1'b1;
  assign idx_cmp     = CMP_W'(cluster_index_i);
  assign scan_last   = ((CNT_W'(scan_q) + CNT_W'(1)) >= count_q);
  assign table_full  = (count_q >= CNT_W'(MAX_CLUSTERS));

  hdc_cluster_mem #(
    .DEPTH (MAX_CLUSTERS),
    .AW    (CIDX_W)
  ) u_mem (
    .clk_i     (clk_i),
    .rd_en_i   (rd_en),
    .rd_addr_i (rd_addr),
    .rd_data_o (rd_data),
    .wr_en_i   (wr_en),
    .wr_addr_i (wr_addr),
    .wr_data_i (wr_data)
  );

  hdc_match u_match (
    .hit_i   (hit_q),
    .entry_i (rd_data),
    .cfg_i   (cfg_q),
    .join_o  (join_hit)
  );

  // row images for a hit that joins the row just read, or opens a new one
  always_comb begin
    join_entry            = rd_data;
    join_entry.probe_end  = 17'(hit_q.probe) + 17'(cfg_q.tile);
    join_entry.target_end = 31'(hit_q.target) + 31'(cfg_q.tile);
    if (rd_data.hits != hdc_pkg::HITS_MAX) begin
      join_entry.hits = rd_data.hits + 16'd1;
    end

    new_entry.probe_start  = hit_q.probe;
    new_entry.probe_end    = 17'(hit_q.probe) + 17'(cfg_q.tile);
    new_entry.target_start = hit_q.target;
    new_entry.target_end   = 31'(hit_q.target) + 31'(cfg_q.tile);
    new_entry.hits         = 16'd1;
    new_entry.seed_diag    = hit_q.diag;
  end

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      hdc_pkg::ST_IDLE: begin
        if (accept) begin
          case (action_i)
            hdc_pkg::ACT_ADD: begin
              state_d = (count_q == '0) ? hdc_pkg::ST_APPEND : hdc_pkg::ST_SCAN_RD;
            end
            hdc_pkg::ACT_READ: state_d = hdc_pkg::ST_RD_ISSUE;
            default:           state_d = hdc_pkg::ST_IDLE;
          endcase
        end
      end
      hdc_pkg::ST_SCAN_RD:  state_d = hdc_pkg::ST_SCAN_CHK;
      hdc_pkg::ST_SCAN_CHK: begin
        if (join_hit) begin
          state_d = hdc_pkg::ST_IDLE;
        end else if (scan_last) begin
          state_d = hdc_pkg::ST_APPEND;
        end else begin
          state_d = hdc_pkg::ST_SCAN_RD;
        end
      end
      hdc_pkg::ST_APPEND:   state_d = hdc_pkg::ST_IDLE;
      hdc_pkg::ST_RD_ISSUE: state_d = hdc_pkg::ST_RD_DONE;
      hdc_pkg::ST_RD_DONE:  state_d = hdc_pkg::ST_IDLE;
      default:              state_d = hdc_pkg::ST_IDLE;
    endcase
  end

  // memory controls; reads and writes sit in different states, so a row written
  // back is only read again in a later cycle and no forwarding is needed
  always_comb begin
    rd_en   = 1'b0;
    rd_addr = scan_q;
    wr_en   = 1'b0;
    wr_addr = scan_q;
    wr_data = join_entry;
    unique case (state_q)
      hdc_pkg::ST_SCAN_RD: rd_en = 1'b1;
      hdc_pkg::ST_SCAN_CHK: begin
        wr_en = join_hit;
      end
      hdc_pkg::ST_APPEND: begin
        wr_en   = !table_full;
        wr_addr = count_q[CIDX_W-1:0];
        wr_data = new_entry;
      end
      hdc_pkg::ST_RD_ISSUE: begin
        rd_en   = idx_ok_q;
        rd_addr = idx_q;
      end
      default: ;
    endcase
  end

  // datapath and control register updates
  always_comb begin
    cfg_d       = cfg_q;
    hit_d       = hit_q;
    scan_d      = scan_q;
    count_d     = count_q;
    ovf_d       = ovf_q;
    idx_d       = idx_q;
    idx_ok_d    = idx_ok_q;
    res_valid_d = 1'b0;
    res_ps_d    = res_ps_q;
    res_pe_d    = res_pe_q;
    res_ts_d    = res_ts_q;
    res_te_d    = res_te_q;
    res_hits_d  = res_hits_q;
    res_total_d = res_total_q;
    res_iv_d    = res_iv_q;
    res_ovf_d   = res_ovf_q;

    if (cfg_valid_i && cfg_ready_o) begin
      unique case (cfg_index_i)
        hdc_pkg::CFG_DIAG_TOL: cfg_d.diag_tol = cfg_data_i[3:0];
        hdc_pkg::CFG_MAX_GAP:  cfg_d.max_gap  = cfg_data_i;
        hdc_pkg::CFG_SLACK:    cfg_d.slack    = cfg_data_i[3:0];
        hdc_pkg::CFG_TILE:     cfg_d.tile     = cfg_data_i[5:0];
        default: ;
      endcase
    end

    unique case (state_q)
      hdc_pkg::ST_IDLE: begin
        if (accept) begin
          case (action_i)
            hdc_pkg::ACT_ADD: begin
              hit_d.probe        = probe_offset_i;
              hit_d.target       = target_offset_i;
              hit_d.diag         = $signed({16'd0, probe_offset_i}) -
                                   $signed({2'd0, target_offset_i});
              hit_d.probe_slack  = 17'(probe_offset_i) + 17'(cfg_q.slack);
              hit_d.target_slack = 31'(target_offset_i) + 31'(cfg_q.slack);
              scan_d             = '0;
            end
            hdc_pkg::ACT_READ: begin
              idx_ok_d = (idx_cmp < CMP_W'(count_q));
              idx_d    = idx_cmp[CIDX_W-1:0];
            end
            hdc_pkg::ACT_CLEAR: begin
              count_d = '0;
              ovf_d   = 1'b0;
            end
            default: ;
          endcase
        end
      end
      hdc_pkg::ST_SCAN_CHK: begin
        if (!join_hit && !scan_last) begin
          scan_d = scan_q + CIDX_W'(1);
        end
      end
      hdc_pkg::ST_APPEND: begin
        if (table_full) begin
          ovf_d = 1'b1;
        end else begin
          count_d = count_q + CNT_W'(1);
        end
      end
      hdc_pkg::ST_RD_DONE: begin
        res_valid_d = 1'b1;
        res_total_d = 11'(count_q);
        res_ovf_d   = ovf_q;
        res_iv_d    = idx_ok_q;
        if (idx_ok_q) begin
          res_ps_d   = rd_data.probe_start;
          res_pe_d   = rd_data.probe_end;
          res_ts_d   = rd_data.target_start;
          res_te_d   = rd_data.target_end;
          res_hits_d = rd_data.hits;
        end else begin
          res_ps_d   = '0;
          res_pe_d   = '0;
          res_ts_d   = '0;
          res_te_d   = '0;
          res_hits_d = '0;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= hdc_pkg::ST_IDLE;
      count_q     <= '0;
      ovf_q       <= 1'b0;
      res_valid_q <= 1'b0;
      cfg_q       <= '{diag_tol: hdc_pkg::DIAG_TOL_RST, max_gap: hdc_pkg::MAX_GAP_RST,
                       slack: hdc_pkg::SLACK_RST, tile: hdc_pkg::TILE_RST};
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      ovf_q       <= ovf_d;
      res_valid_q <= res_valid_d;
      cfg_q       <= cfg_d;
    end
  end

  always_ff @(posedge clk_i) begin
    hit_q       <= hit_d;
    scan_q      <= scan_d;
    idx_q       <= idx_d;
    idx_ok_q    <= idx_ok_d;
    res_ps_q    <= res_ps_d;
    res_pe_q    <= res_pe_d;
    res_ts_q    <= res_ts_d;
    res_te_q    <= res_te_d;
    res_hits_q  <= res_hits_d;
    res_total_q <= res_total_d;
    res_iv_q    <= res_iv_d;
    res_ovf_q   <= res_ovf_d;
  end

  assign result_valid_o  = res_valid_q;
  assign probe_start_o   = res_ps_q;
  assign probe_end_o     = res_pe_q;
  assign target_start_o  = res_ts_q;
  assign target_end_o    = res_te_q;
  assign hit_total_o     = res_hits_q;
  assign cluster_total_o = res_total_q;
  assign index_valid_o   = res_iv_q;
  assign overflowed_o    = res_ovf_q;

  // a result only follows the read response state
  a_result_from_read: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |-> $past(state_q == hdc_pkg::ST_RD_DONE))
    else $error("result strobe without a read transaction");

  // the cluster count never passes the table depth
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CNT_W'(MAX_CLUSTERS))
    else $error("cluster count beyond table depth");

  // table writes only happen while an add is in progress
  a_write_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    wr_en |-> (state_q == hdc_pkg::ST_SCAN_CHK || state_q == hdc_pkg::ST_APPEND))
    else $error("table write outside an add");

  // an add on an empty table opens a cluster at once
  a_empty_append: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && action_i == hdc_pkg::ACT_ADD && count_q == '0)
      |=> (state_q == hdc_pkg::ST_APPEND))
    else $error("add on empty table did not append");

endmodule

`default_nettype wire

// ----- dv/hdc_cluster_checker.sv -----
// hdc_cluster_checker: watches the hit, config and readout ports of hit_diagonal_clustering,
// keeps its own copy of the cluster table and compares every readout field by field
// depends on hdc_pkg
`timescale 1ns / 1ps

module hdc_cluster_checker #(
  parameter int unsigned MAX_CLUSTERS = hdc_pkg::MAX_CLUSTERS_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  input  logic        busy_i,
  input  logic [1:0]  action_i,
  input  logic [15:0] probe_offset_i,
  input  logic [29:0] target_offset_i,
  input  logic [9:0]  cluster_index_i,
  input  logic        cfg_valid_i,
  input  logic        cfg_ready_i,
  input  logic [1:0]  cfg_index_i,
  input  logic [7:0]  cfg_data_i,
  input  logic        result_valid_i,
  input  logic [15:0] probe_start_i,
  input  logic [16:0] probe_end_i,
  input  logic [29:0] target_start_i,
  input  logic [30:0] target_end_i,
  input  logic [15:0] hit_total_i,
  input  logic [10:0] cluster_total_i,
  input  logic        index_valid_i,
  input  logic        overflowed_i,
  output int unsigned mismatch_count_o,
  output int unsigned pending_reads_o
);
  import hdc_pkg::*;

  typedef struct packed {
    logic [15:0] probe_start;
    logic [16:0] probe_end;
    logic [29:0] target_start;
    logic [30:0] target_end;
    logic [15:0] hit_total;
    logic [10:0] cluster_total;
    logic        index_valid;
    logic        overflowed;
  } readout_t;

  logic [15:0] tab_probe_start  [MAX_CLUSTERS];
  logic [16:0] tab_probe_end    [MAX_CLUSTERS];
  logic [29:0] tab_target_start [MAX_CLUSTERS];
  logic [30:0] tab_target_end   [MAX_CLUSTERS];
  logic [15:0] tab_hits         [MAX_CLUSTERS];
  int unsigned n_clusters;
  logic        dropped_flag;
  hdc_cfg_t    knobs;
  readout_t    expected_readouts [$];
  int unsigned mismatches;

  function automatic bit in_window(input longint pos, input longint tail);
    return pos >= tail - longint'(knobs.slack) && pos <= tail + longint'(knobs.max_gap);
  endfunction

  // first cluster in creation order that takes the hit wins
  function automatic void merge_hit(input logic [15:0] p, input logic [29:0] t);
    longint hit_diag;
    longint spread;
    hit_diag = longint'(p) - longint'(t);
    for (int k = 0; k < n_clusters; k++) begin
      spread = hit_diag - (longint'(tab_probe_start[k]) - longint'(tab_target_start[k]));
      if (spread < 0)
        spread = -spread;
      if (spread <= longint'(knobs.diag_tol) &&
          in_window(longint'(p), longint'(tab_probe_end[k])) &&
          in_window(longint'(t), longint'(tab_target_end[k]))) begin
        tab_probe_end[k]  = {1'b0, p} + 17'(knobs.tile);
        tab_target_end[k] = {1'b0, t} + 31'(knobs.tile);
        if (tab_hits[k] != HITS_MAX)
          tab_hits[k] = tab_hits[k] + 16'd1;
        return;
      end
    end
    if (n_clusters >= MAX_CLUSTERS) begin
      dropped_flag = 1'b1;
      return;
    end
    tab_probe_start[n_clusters]  = p;
    tab_target_start[n_clusters] = t;
    tab_probe_end[n_clusters]    = {1'b0, p} + 17'(knobs.tile);
    tab_target_end[n_clusters]   = {1'b0, t} + 31'(knobs.tile);
    tab_hits[n_clusters]         = 16'd1;
    n_clusters++;
  endfunction

  function automatic readout_t cluster_readout(input logic [9:0] idx);
    readout_t r;
    r = '0;
    if (idx < n_clusters) begin
      r.probe_start  = tab_probe_start[idx];
      r.probe_end    = tab_probe_end[idx];
      r.target_start = tab_target_start[idx];
      r.target_end   = tab_target_end[idx];
      r.hit_total    = tab_hits[idx];
      r.index_valid  = 1'b1;
    end
    r.cluster_total = 11'(n_clusters);
    r.overflowed    = dropped_flag;
    return r;
  endfunction

  task automatic check_field(input string name, input logic [63:0] want,
                             input logic [63:0] got);
    if (got !== want) begin
      mismatches++;
      $display("%0t: %s expected 0x%0h, got 0x%0h", $time, name, want, got);
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin : monitor
    readout_t want;
    if (!rst_ni) begin
      n_clusters     = 0;
      dropped_flag   = 1'b0;
      knobs.diag_tol = DIAG_TOL_RST;
      knobs.max_gap  = MAX_GAP_RST;
      knobs.slack    = SLACK_RST;
      knobs.tile     = TILE_RST;
      expected_readouts.delete();
      mismatches       = 0;
      mismatch_count_o <= 0;
      pending_reads_o  <= 0;
    end else begin
      // older readouts retire before a new request joins the queue
      if (result_valid_i) begin
        if (expected_readouts.size() == 0) begin
          mismatches++;
          $display("%0t: readout expected none, got cluster_total %0d index_valid %0b",
                   $time, cluster_total_i, index_valid_i);
        end else begin
          want = expected_readouts.pop_front();
          check_field("probe_start", want.probe_start, probe_start_i);
          check_field("probe_end", want.probe_end, probe_end_i);
          check_field("target_start", want.target_start, target_start_i);
          check_field("target_end", want.target_end, target_end_i);
          check_field("hit_total", want.hit_total, hit_total_i);
          check_field("cluster_total", want.cluster_total, cluster_total_i);
          check_field("index_valid", want.index_valid, index_valid_i);
          check_field("overflowed", want.overflowed, overflowed_i);
        end
      end

      if (start_i && !busy_i) begin
        case (action_i)
          ACT_ADD:   merge_hit(probe_offset_i, target_offset_i);
          ACT_READ:  expected_readouts.push_back(cluster_readout(cluster_index_i));
          ACT_CLEAR: begin
            n_clusters   = 0;
            dropped_flag = 1'b0;
          end
          default: ;
        endcase
      end

      if (cfg_valid_i && cfg_ready_i) begin
        case (hdc_cfg_idx_e'(cfg_index_i))
          CFG_DIAG_TOL: knobs.diag_tol = cfg_data_i[3:0];
          CFG_MAX_GAP:  knobs.max_gap  = cfg_data_i;
          CFG_SLACK:    knobs.slack    = cfg_data_i[3:0];
          CFG_TILE:     knobs.tile     = cfg_data_i[5:0];
          default: ;
        endcase
      end

      mismatch_count_o <= mismatches;
      pending_reads_o  <= expected_readouts.size();
    end
  end

endmodule

// ----- dv/tb_hit_diagonal_clustering.sv -----
// tb_hit_diagonal_clustering: stimulus and verdict for hit_diagonal_clustering, with
// directed hits, a repeated join run, a full table run and random hit chains
// depends on hdc_pkg, hit_diagonal_clustering and hdc_cluster_checker
`timescale 1ns / 1ps

module tb_hit_diagonal_clustering;
  import hdc_pkg::*;

  localparam int unsigned TABLE_DEPTH   = MAX_CLUSTERS_DEF;
  localparam logic [1:0]  ACT_UNUSED    = 2'd3;
  localparam int unsigned DRAIN_CYCLES  = 2 * TABLE_DEPTH + 8;
  localparam longint unsigned CYCLE_LIMIT = 64'd20_000_000;
  localparam int unsigned TARGET_MAX    = 32'h3FFF_FFFF;
  localparam int unsigned PHASE_ITEMS   = 140;
  localparam int unsigned RANDOM_PHASES = 6;
  localparam int unsigned CHAINS        = 4;
  localparam int unsigned FILL_HITS     = TABLE_DEPTH + 6;
  localparam int unsigned SAT_HITS      = 20;

  logic        clk_i;
  logic        rst_ni;
  logic        start_i;
  logic        busy_o;
  logic [1:0]  action_i;
  logic [15:0] probe_offset_i;
  logic [29:0] target_offset_i;
  logic [9:0]  cluster_index_i;
  logic        cfg_valid_i;
  logic        cfg_ready_o;
  logic [1:0]  cfg_index_i;
  logic [7:0]  cfg_data_i;
  logic        result_valid_o;
  logic [15:0] probe_start_o;
  logic [16:0] probe_end_o;
  logic [29:0] target_start_o;
  logic [30:0] target_end_o;
  logic [15:0] hit_total_o;
  logic [10:0] cluster_total_o;
  logic        index_valid_o;
  logic        overflowed_o;

  int unsigned mismatch_count;
  int unsigned pending_reads;
  longint unsigned cycle_count = 0;

  // register values as last written, used only to shape hit chains
  int cur_tol, cur_gap, cur_slack, cur_tile;

  logic [15:0] chain_p    [CHAINS];
  longint      chain_seed [CHAINS];
  bit          chain_live [CHAINS];

  hit_diagonal_clustering uut (
    .clk_i(clk_i), .rst_ni(rst_ni), .start_i(start_i), .busy_o(busy_o),
    .action_i(action_i), .probe_offset_i(probe_offset_i),
    .target_offset_i(target_offset_i), .cluster_index_i(cluster_index_i),
    .cfg_valid_i(cfg_valid_i), .cfg_ready_o(cfg_ready_o),
    .cfg_index_i(cfg_index_i), .cfg_data_i(cfg_data_i),
    .result_valid_o(result_valid_o), .probe_start_o(probe_start_o),
    .probe_end_o(probe_end_o), .target_start_o(target_start_o),
    .target_end_o(target_end_o), .hit_total_o(hit_total_o),
    .cluster_total_o(cluster_total_o), .index_valid_o(index_valid_o),
    .overflowed_o(overflowed_o)
  );

  hdc_cluster_checker #(.MAX_CLUSTERS(TABLE_DEPTH)) u_checker (
    .clk_i(clk_i), .rst_ni(rst_ni), .start_i(start_i), .busy_i(busy_o),
    .action_i(action_i), .probe_offset_i(probe_offset_i),
    .target_offset_i(target_offset_i), .cluster_index_i(cluster_index_i),
    .cfg_valid_i(cfg_valid_i), .cfg_ready_i(cfg_ready_o),
    .cfg_index_i(cfg_index_i), .cfg_data_i(cfg_data_i),
    .result_valid_i(result_valid_o), .probe_start_i(probe_start_o),
    .probe_end_i(probe_end_o), .target_start_i(target_start_o),
    .target_end_i(target_end_o), .hit_total_i(hit_total_o),
    .cluster_total_i(cluster_total_o), .index_valid_i(index_valid_o),
    .overflowed_i(overflowed_o), .mismatch_count_o(mismatch_count),
    .pending_reads_o(pending_reads)
  );

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("Mismatches found");
      $finish;
    end
  end

  // start stays high across back-to-back transactions
  task automatic send(input logic [1:0] act, input logic [15:0] p, input logic [29:0] t,
                      input logic [9:0] idx);
    start_i         <= 1'b1;
    action_i        <= act;
    probe_offset_i  <= p;
    target_offset_i <= t;
    cluster_index_i <= idx;
    @(posedge clk_i);
    while (busy_o) @(posedge clk_i);
  endtask

  task automatic offer_hit(input logic [15:0] p, input logic [29:0] t);
    send(ACT_ADD, p, t, 10'($urandom));
  endtask

  task automatic read_cluster(input logic [9:0] idx);
    send(ACT_READ, 16'($urandom), 30'($urandom), idx);
  endtask

  task automatic pause(input int unsigned n);
    start_i <= 1'b0;
    repeat (n) @(posedge clk_i);
  endtask

  task automatic write_reg(input hdc_cfg_idx_e idx, input logic [7:0] data);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    cfg_valid_i <= 1'b0;
    @(posedge clk_i);
  endtask

  // adds give no readout, so wait out the longest table scan too
  task automatic settle();
    start_i <= 1'b0;
    @(posedge clk_i);
    while (pending_reads != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  task automatic load_knobs(input logic [7:0] tol, input logic [7:0] gap,
                            input logic [7:0] slack, input logic [7:0] tile);
    write_reg(CFG_DIAG_TOL, tol);
    write_reg(CFG_MAX_GAP, gap);
    write_reg(CFG_SLACK, slack);
    write_reg(CFG_TILE, tile);
    cur_tol   = tol[3:0];
    cur_gap   = gap;
    cur_slack = slack[3:0];
    cur_tile  = tile[5:0];
  endtask

  // next hit of a random chain: steps inside the join window with diagonal jitter
  task automatic chain_hit(output logic [15:0] p, output logic [29:0] t);
    int     c;
    longint np, nt, jitter;
    c  = $urandom_range(0, CHAINS - 1);
    np = -1;
    nt = -1;
    if (chain_live[c] && $urandom_range(0, 11) != 0) begin
      np = longint'(chain_p[c]) + cur_tile - cur_slack +
           longint'($urandom_range(0, cur_slack + cur_gap));
      jitter = longint'($urandom_range(0, 2 * cur_tol)) - cur_tol;
      nt = np - chain_seed[c] - jitter;
    end
    if (np < 0 || np > 65535 || nt < 0 || nt > longint'(TARGET_MAX)) begin
      np = longint'($urandom_range(0, 16'hFFFF));
      nt = longint'($urandom_range(0, TARGET_MAX));
      chain_seed[c] = np - nt;
    end
    chain_live[c] = 1'b1;
    chain_p[c]    = np[15:0];
    p = np[15:0];
    t = nt[29:0];
  endtask

  task automatic run_random(input int unsigned n_items, input bit with_gaps);
    int unsigned done;
    int unsigned pick;
    logic [15:0] p;
    logic [29:0] t;
    done = 0;
    while (done < n_items) begin
      pick = $urandom_range(0, 99);
      if (pick < 60) begin
        chain_hit(p, t);
        offer_hit(p, t);
        done++;
      end else if (pick < 78) begin
        read_cluster(10'($urandom_range(0, 24)));
        done++;
      end else if (pick < 83) begin
        read_cluster(10'($urandom));
        done++;
      end else if (pick < 93) begin
        offer_hit(16'($urandom), 30'($urandom));
        done++;
      end else if (pick < 96) begin
        send(ACT_CLEAR, 16'($urandom), 30'($urandom), 10'($urandom));
        done++;
      end else begin
        send(ACT_UNUSED, 16'($urandom), 30'($urandom), 10'($urandom));
      end
      if (with_gaps && $urandom_range(0, 7) == 0)
        pause($urandom_range(1, 16));
    end
  endtask

  initial begin : stimulus
    logic [15:0] fill_p [FILL_HITS];
    logic [15:0] sat_p;
    logic [29:0] sat_t;

    rst_ni          = 1'b0;
    start_i         = 1'b0;
    action_i        = ACT_ADD;
    probe_offset_i  = '0;
    target_offset_i = '0;
    cluster_index_i = '0;
    cfg_valid_i     = 1'b0;
    cfg_index_i     = CFG_DIAG_TOL;
    cfg_data_i      = '0;
    cur_tol         = DIAG_TOL_RST;
    cur_gap         = MAX_GAP_RST;
    cur_slack       = SLACK_RST;
    cur_tile        = TILE_RST;
    foreach (chain_live[c]) begin
      chain_live[c] = 1'b0;
      chain_p[c]    = '0;
      chain_seed[c] = 0;
    end
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed part under reset register values
    read_cluster(10'd0);
    offer_hit(16'd0, 30'd0);
    offer_hit(16'hFFFF, 30'h3FFF_FFFF);
    offer_hit(16'hFFFF, 30'd0);
    offer_hit(16'd0, 30'h3FFF_FFFF);
    offer_hit(16'd20, 30'd20);
    offer_hit(16'd39, 30'd37);
    offer_hit(16'd60, 30'd57);
    offer_hit(16'd53, 30'd53);
    offer_hit(16'd200, 30'd200);
    send(ACT_UNUSED, 16'd5, 30'd5, 10'd0);
    for (int i = 0; i < 7; i++)
      read_cluster(10'(i));
    read_cluster(10'h3FF);
    send(ACT_CLEAR, 16'hFFFF, 30'h3FFF_FFFF, 10'h3FF);
    read_cluster(10'd0);
    read_cluster(10'd1);
    settle();

    // one cluster absorbs the same hit over and over
    load_knobs(8'd0, 8'd0, 8'd0, 8'd0);
    send(ACT_CLEAR, '0, '0, '0);
    sat_p = 16'($urandom);
    sat_t = 30'($urandom);
    for (int n = 1; n <= SAT_HITS; n++) begin
      offer_hit(sat_p, sat_t);
      if (n >= SAT_HITS - 6)
        read_cluster(10'd0);
    end
    settle();

    // distinct diagonals with zero tolerance: every hit opens a cluster until full
    load_knobs(8'd0, 8'd0, 8'd0, 8'd32);
    send(ACT_CLEAR, '0, '0, '0);
    for (int k = 0; k < FILL_HITS; k++) begin
      fill_p[k] = 16'($urandom_range(0, 60000));
      offer_hit(fill_p[k], 30'(fill_p[k] + k));
    end
    read_cluster(10'd0);
    read_cluster(10'h3FF);
    for (int i = 0; i < 3; i++)
      read_cluster(10'($urandom));
    // joins still work on a full table
    offer_hit(fill_p[5] + 16'd32, 30'(fill_p[5] + 5 + 32));
    read_cluster(10'd5);
    offer_hit(fill_p[1023] + 16'd32, 30'(fill_p[1023] + 1023 + 32));
    read_cluster(10'h3FF);
    send(ACT_CLEAR, '0, '0, '0);
    read_cluster(10'd0);
    settle();

    for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
      case (ph)
        0:       load_knobs(8'h00, 8'h00, 8'h00, 8'h00);
        1:       load_knobs(8'hFF, 8'hFF, 8'hFF, 8'hFF);
        RANDOM_PHASES - 1:
                 load_knobs(8'd2, 8'd48, 8'd2, 8'd16);
        default: load_knobs(8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom));
      endcase
      run_random(PHASE_ITEMS, ph != RANDOM_PHASES - 1);
      settle();
    end

    if (mismatch_count == 0)
      $display("No mismatches found");
    else
      $display("Mismatches found");
    $finish;
  end

endmodule
